// ----- rtl/core/frame_prefetch_order_generator_unit_assert.svh -----
// Assertion macros shared by the frame prefetch order generator RTL.
`ifndef FRAME_PREFETCH_ORDER_GENERATOR_UNIT_ASSERT_SVH
`define FRAME_PREFETCH_ORDER_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define FPOG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define FPOG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fpog_pkg.sv -----
// Package: widths, codes, scan types and cursor seed helpers.
`timescale 1ns / 1ps
package fpog_pkg;

  localparam int FRAME_BITS = 24;
  localparam int MAX_RANGES = 16;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int ENTRY_W    = 2 * FRAME_BITS;
  localparam int SUM_W      = FRAME_BITS + 2;

  typedef logic [FRAME_BITS-1:0] frame_t;

  localparam frame_t FRAME_MAX = {FRAME_BITS{1'b1}};

  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_START  = 3'd2;
  localparam logic [2:0] OP_NEXT   = 3'd3;
  localparam logic [2:0] OP_LIMIT  = 3'd4;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_BWD  = 2'd1;
  localparam logic [1:0] MODE_PING = 2'd2;

  localparam logic [1:0] KIND_SUM  = 2'd0;
  localparam logic [1:0] KIND_UP   = 2'd1;
  localparam logic [1:0] KIND_DOWN = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    frame_t     n;
    frame_t     start;
    frame_t     total;
    frame_t     lower;
    frame_t     upper;
    frame_t     first;
    frame_t     last;
  } scan_req_t;

  typedef struct packed {
    frame_t n;
    frame_t total;
    frame_t lower;
    frame_t upper;
    logic   hit;
  } scan_rsp_t;

  // Candidate before snapping into the table: wraps at the span ends.
  function automatic frame_t seed_up(frame_t f, frame_t lo, frame_t hi);
    return (f == hi) ? lo : frame_t'(f + frame_t'(1));
  endfunction

  function automatic frame_t seed_down(frame_t f, frame_t lo, frame_t hi);
    return (f == lo) ? hi : frame_t'(f - frame_t'(1));
  endfunction

endpackage

// ----- rtl/core/fpog_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fpog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/fpog_scan_unit.sv -----
// Shared per-entry compare unit: frame count and gap search, or cursor snap.
`timescale 1ns / 1ps
module fpog_scan_unit import fpog_pkg::*; (
  input  scan_req_t req,
  output scan_rsp_t rsp
);

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum = SUM_W'(req.total) + SUM_W'(frame_t'(req.last - req.first)) + SUM_W'(1);
    rsp.n     = req.n;
    rsp.total = req.total;
    rsp.lower = req.lower;
    rsp.upper = req.upper;
    rsp.hit   = 1'b0;
    unique case (req.kind)
      KIND_SUM: begin
        rsp.total = (sum > SUM_W'(FRAME_MAX)) ? FRAME_MAX : sum[FRAME_BITS-1:0];
        if (req.start >= req.first && req.start <= req.last) begin
          rsp.lower = req.start;
          rsp.upper = req.start;
        end else if (req.start > req.last && req.lower < req.last) begin
          rsp.lower = req.last;
        end else if (req.start < req.first && req.upper > req.first) begin
          rsp.upper = req.first;
        end
      end
      KIND_UP: begin
        // first range reaching n: n stays inside it or jumps to its start
        if (req.last >= req.n) begin
          rsp.hit = 1'b1;
          rsp.n   = (req.first > req.n) ? req.first : req.n;
        end
      end
      KIND_DOWN: begin
        if (req.first <= req.n) begin
          rsp.hit = 1'b1;
          rsp.n   = (req.last < req.n) ? req.last : req.n;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/frame_prefetch_order_generator_unit.sv -----
// Top level: range table, scan sequencer and result register.
//
//  channel | ports                         | payload
//  in      | in_tvalid/in_tready           | tuser: op; tdata: start, end, frame, limit
//  out     | out_tvalid/out_tready         | tuser: frame_valid; tdata: index, left
//  cfg     | cfg_wr_en                     | cfg_wr_data: iteration_mode
//
// Clear, append, limit and unknown ops: result registered in the accepting cycle.
// Next: one table read per cycle, stops at the hit.
// Start: one table walk to total, optionally a second walk to snap a cursor,
//   then the result is posted from S_DONE once the result register is free.
// Input is held off outside S_IDLE, or while a full result register is not drained.
// rst_n is synchronous; the range table has no reset.
`timescale 1ns / 1ps
`include "frame_prefetch_order_generator_unit_assert.svh"
module frame_prefetch_order_generator_unit import fpog_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // op
  input  logic [2:0]                in_tuser,
  // range_start, range_end, start_frame, iteration_limit
  input  logic [4*FRAME_BITS-1:0]   in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // frame_valid
  output logic                      out_tuser,
  // frame_index, frames_left
  output logic [2*FRAME_BITS-1:0]   out_tdata,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_wr_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  frame_t           n_r, n_nxt;
  frame_t           tot_r, tot_nxt;
  frame_t           lo_r, lo_nxt;
  frame_t           up_r, up_nxt;
  frame_t           start_r, start_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  frame_t           span_lo_r, span_lo_nxt;
  frame_t           span_hi_r, span_hi_nxt;
  frame_t           fwd_r, fwd_nxt;
  frame_t           bwd_r, bwd_nxt;
  logic             mf_r, mf_nxt;
  frame_t           rem_r, rem_nxt;
  logic [1:0]       mode_r, mode_nxt;
  frame_t           frame_r, frame_nxt;
  logic             fv_r, fv_nxt;
  logic             out_valid_r, out_valid_nxt;
  frame_t           out_frame_r, out_frame_nxt;
  logic             out_fv_r, out_fv_nxt;
  frame_t           out_left_r, out_left_nxt;

  logic             in_acc;
  logic             issue;
  logic             fin;
  logic             eq;
  logic             mfv;
  logic [CNT_W-1:0] rd_pos;
  logic             ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  frame_t           f_start, f_end, f_frame, f_limit;
  scan_req_t        req;
  scan_rsp_t        rsp;

  assign f_start = in_tdata[FRAME_BITS-1:0];
  assign f_end   = in_tdata[2*FRAME_BITS-1:FRAME_BITS];
  assign f_frame = in_tdata[3*FRAME_BITS-1:2*FRAME_BITS];
  assign f_limit = in_tdata[4*FRAME_BITS-1:3*FRAME_BITS];

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fv_r;
  assign out_tdata  = {out_left_r, out_frame_r};

  // Table walk: ascending for sum and step up, descending for step down.
  assign issue  = (state_r == S_SCAN) && (left_r != '0);
  assign rd_pos = (kind_r == KIND_DOWN) ? CNT_W'(left_r - CNT_W'(1))
                                        : CNT_W'(cnt_r - left_r);
  assign ram_we = in_acc && (in_tuser == OP_APPEND) &&
                  (cnt_r < CNT_W'(MAX_RANGES)) && (f_end >= f_start);

  fpog_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data ({f_end, f_start}),
    .rd_en   (issue),
    .rd_addr (rd_pos[IDX_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    req.kind  = kind_r;
    req.n     = n_r;
    req.start = start_r;
    req.total = tot_r;
    req.lower = lo_r;
    req.upper = up_r;
    req.first = ram_rdata[FRAME_BITS-1:0];
    req.last  = ram_rdata[ENTRY_W-1:FRAME_BITS];
  end

  fpog_scan_unit u_scan (
    .req (req),
    .rsp (rsp)
  );

  assign fin = rd_vld_r && (rsp.hit || (left_r == '0));
  assign eq  = (rsp.lower == rsp.upper);
  assign mfv = (mode_r == MODE_PING) ? 1'b0 : (mode_r == MODE_FWD);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    rd_vld_nxt    = 1'b0;
    n_nxt         = n_r;
    tot_nxt       = tot_r;
    lo_nxt        = lo_r;
    up_nxt        = up_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    span_lo_nxt   = span_lo_r;
    span_hi_nxt   = span_hi_r;
    fwd_nxt       = fwd_r;
    bwd_nxt       = bwd_r;
    mf_nxt        = mf_r;
    rem_nxt       = rem_r;
    mode_nxt      = cfg_wr_en ? cfg_wr_data : mode_r;
    frame_nxt     = frame_r;
    fv_nxt        = fv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_frame_nxt = out_frame_r;
    out_fv_nxt    = out_fv_r;
    out_left_nxt  = out_left_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // default: immediate result with no frame
          out_valid_nxt = 1'b1;
          out_frame_nxt = '0;
          out_fv_nxt    = 1'b0;
          out_left_nxt  = rem_r;
          unique case (in_tuser)
            OP_CLEAR: begin
              cnt_nxt      = '0;
              rem_nxt      = '0;
              out_left_nxt = '0;
            end
            OP_APPEND: begin
              if (ram_we) begin
                if (cnt_r == '0) begin
                  span_lo_nxt = f_start;
                end
                span_hi_nxt  = f_end;
                cnt_nxt      = CNT_W'(cnt_r + CNT_W'(1));
                rem_nxt      = '0;
                out_left_nxt = '0;
              end
            end
            OP_START: begin
              mf_nxt = (mode_r == MODE_FWD);
              if (cnt_r == '0) begin
                rem_nxt      = '0;
                fwd_nxt      = '0;
                bwd_nxt      = '0;
                out_left_nxt = '0;
              end else begin
                out_valid_nxt = out_valid_r && !out_tready;
                tot_nxt       = '0;
                lo_nxt        = span_lo_r;
                up_nxt        = span_hi_r;
                start_nxt     = f_frame;
                kind_nxt      = KIND_SUM;
                left_nxt      = cnt_r;
                frame_nxt     = '0;
                fv_nxt        = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            OP_NEXT: begin
              if (cnt_r != '0 && rem_r != '0) begin
                out_valid_nxt = out_valid_r && !out_tready;
                frame_nxt     = mf_r ? fwd_r : bwd_r;
                fv_nxt        = 1'b1;
                if (mf_r) begin
                  n_nxt    = seed_up(fwd_r, span_lo_r, span_hi_r);
                  kind_nxt = KIND_UP;
                end else begin
                  n_nxt    = seed_down(bwd_r, span_lo_r, span_hi_r);
                  kind_nxt = KIND_DOWN;
                end
                if (mode_r == MODE_PING) begin
                  mf_nxt = !mf_r;
                end
                rem_nxt   = frame_t'(rem_r - frame_t'(1));
                left_nxt  = cnt_r;
                state_nxt = S_SCAN;
              end
            end
            OP_LIMIT: begin
              if (f_limit < rem_r) begin
                rem_nxt      = f_limit;
                out_left_nxt = f_limit;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          left_nxt = CNT_W'(left_r - CNT_W'(1));
        end
        rd_vld_nxt = issue;
        if (rd_vld_r) begin
          n_nxt   = rsp.n;
          tot_nxt = rsp.total;
          lo_nxt  = rsp.lower;
          up_nxt  = rsp.upper;
        end
        if (fin) begin
          rd_vld_nxt = 1'b0;
          left_nxt   = '0;
          state_nxt  = S_DONE;
          unique case (kind_r)
            KIND_SUM: begin
              rem_nxt = rsp.total;
              if (eq) begin
                // start frame sits on the table: snap the other cursor
                mf_nxt     = mfv;
                left_nxt   = cnt_r;
                state_nxt  = S_SCAN;
                if (mfv) begin
                  fwd_nxt  = rsp.upper;
                  n_nxt    = seed_down(rsp.upper, span_lo_r, span_hi_r);
                  kind_nxt = KIND_DOWN;
                end else begin
                  bwd_nxt  = rsp.upper;
                  n_nxt    = seed_up(rsp.upper, span_lo_r, span_hi_r);
                  kind_nxt = KIND_UP;
                end
              end else begin
                mf_nxt  = (mode_r == MODE_PING) ? 1'b1 : (mode_r == MODE_FWD);
                fwd_nxt = rsp.upper;
                bwd_nxt = rsp.lower;
              end
            end
            KIND_UP: begin
              fwd_nxt = rsp.n;
            end
            default: begin
              bwd_nxt = rsp.n;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_frame_nxt = frame_r;
          out_fv_nxt    = fv_r;
          out_left_nxt  = rem_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_r      <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      fwd_r       <= '0;
      bwd_r       <= '0;
      mf_r        <= 1'b1;
      rem_r       <= '0;
      mode_r      <= MODE_FWD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_r      <= left_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_r       <= cnt_nxt;
      fwd_r       <= fwd_nxt;
      bwd_r       <= bwd_nxt;
      mf_r        <= mf_nxt;
      rem_r       <= rem_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    n_r         <= n_nxt;
    tot_r       <= tot_nxt;
    lo_r        <= lo_nxt;
    up_r        <= up_nxt;
    start_r     <= start_nxt;
    span_lo_r   <= span_lo_nxt;
    span_hi_r   <= span_hi_nxt;
    frame_r     <= frame_nxt;
    fv_r        <= fv_nxt;
    out_frame_r <= out_frame_nxt;
    out_fv_r    <= out_fv_nxt;
    out_left_r  <= out_left_nxt;
  end

  `FPOG_ASSERT_NOW(a_busy_blocks_input, state_r != S_IDLE, !in_tready, "input taken during scan")
  `FPOG_ASSERT_NEXT(a_next_counts_down, in_acc && in_tuser == OP_NEXT && rem_r != '0 && cnt_r != '0, rem_r == frame_t'($past(rem_r) - frame_t'(1)), "frames left not decremented")
  `FPOG_ASSERT_NEXT(a_full_table_holds, in_acc && in_tuser == OP_APPEND && cnt_r == CNT_W'(MAX_RANGES), $stable(cnt_r), "append grew a full table")
  `FPOG_ASSERT_NOW(a_no_frame_is_zero, out_tvalid && !out_tuser, out_tdata[FRAME_BITS-1:0] == '0, "frame index set without a frame")

endmodule
